@@ hdl/bstk_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstk_pkg
// Shared types and codes for the bounded stack with palindrome check.
// ---------------------------------------------------------------------------
package bstk_pkg;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PAL  = 2'd2,
      OP_SHOW = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_RESP,
      CS_POP_RD,
      CS_PAL_CMP,
      CS_SHOW_RD
   } ctrl_state_type;

   // One result item as it leaves the sequencer.
   typedef struct packed {
      status_type         status;
      logic signed [31:0] result_value;
      logic               is_palindrome;
      logic [4:0]         entry_count;
      logic               last_result;
   } rsp_item_type;

endpackage

@@ hdl/bounded_stack_with_palindrome_check.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_stack_with_palindrome_check
// Fixed-depth LIFO of signed 32-bit words with pop, palindrome check and
// bottom-to-top display, held in a dual-read entry store.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  ---------------------------------------------------
//  req_*     in         one request: opcode in tuser, data_value in tdata
//  rsp_*     out        result items: status in tuser, value/flags in tdata,
//                       last result of a request on tlast
//
//  Push, pop and a failed or trivial request go from accept through dispatch
//  to a result state and then into the output register; the pop read
//  overlaps dispatch. The sequencer is ready for the next request in the
//  cycle after its last result is taken. Palindrome walks one mirrored pair
//  per cycle through both read ports. Display sends one entry per cycle
//  while the result channel is not stalled. Reset clears the fill count,
//  sequencer and output valid flag; stored words are not cleared. A stall
//  on rsp_tready holds the sequencer on the current result.
//
module bounded_stack_with_palindrome_check #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tuser,   // [1:0] opcode, [7:2] zero
   input  logic [31:0] req_tdata,   // [31:0] data_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tuser,   // [1:0] status, [7:2] zero
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [32] is_palindrome,
                                    // [37:33] entry_count, [39:38] zero
   output logic        rsp_tlast    // last_result
);

   localparam int AW = $clog2(DEPTH);

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic signed [31:0]     wr_data;
   logic [AW-1:0]          rd_addr_a;
   logic [AW-1:0]          rd_addr_b;
   logic signed [31:0]     rd_data_a;
   logic signed [31:0]     rd_data_b;

   logic                   res_valid;
   logic                   res_ready;
   bstk_pkg::rsp_item_type res_item;

   // output register parts the sequencer from the result channel
   logic                   out_valid_ff, out_valid_in;
   bstk_pkg::rsp_item_type out_item_ff, out_item_in;

   bstk_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bstk_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (bstk_pkg::op_type'(req_tuser[1:0])),
      .req_data  (req_tdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // take a new result when the register is empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_item_in  = res_item;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {6'b0, out_item_ff.status};
   assign rsp_tdata  = {2'b0, out_item_ff.entry_count, out_item_ff.is_palindrome,
                        out_item_ff.result_value};
   assign rsp_tlast  = out_item_ff.last_result;

endmodule

@@ hdl/bstk_mem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstk_mem
// Entry store: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module bstk_mem #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic signed [31:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic signed [31:0]       rd_data_a,
   output logic signed [31:0]       rd_data_b
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_a_ff;
   logic signed [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/bstk_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstk_ctrl
// Sequencer: decodes a request, updates the fill count, drives the entry
// store ports and builds result items.
// ---------------------------------------------------------------------------
module bstk_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bstk_pkg::op_type         req_op,
   input  logic signed [31:0]       req_data,
   output logic                     res_valid,
   input  logic                     res_ready,
   output bstk_pkg::rsp_item_type   res_item,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic signed [31:0]       wr_data,
   output logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [$clog2(DEPTH)-1:0] rd_addr_b,
   input  logic signed [31:0]       rd_data_a,
   input  logic signed [31:0]       rd_data_b
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   bstk_pkg::ctrl_state_type state_ff, state_in;
   bstk_pkg::op_type         op_ff, op_in;
   bstk_pkg::status_type     status_ff, status_in;
   logic signed [31:0]       data_ff, data_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_a_ff, idx_a_in;
   logic [AW-1:0]            idx_b_ff, idx_b_in;
   logic                     pal_ff, pal_in;

   logic          is_full;
   logic          is_empty;
   logic [AW:0]   span;
   logic          show_last;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign span      = {1'b0, idx_b_ff} - {1'b0, idx_a_ff};
   assign show_last = ((CW'(idx_a_ff) + CW'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bstk_pkg::CS_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      pal_ff    <= pal_in;
      idx_a_ff  <= idx_a_in;
      idx_b_ff  <= idx_b_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      data_in   = data_ff;
      status_in = status_ff;
      pal_in    = pal_ff;
      count_in  = count_ff;
      idx_a_in  = idx_a_ff;
      idx_b_in  = idx_b_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;

      res_item.status        = status_ff;
      res_item.result_value  = '0;
      res_item.is_palindrome = pal_ff;
      res_item.entry_count   = 5'(count_ff);
      res_item.last_result   = 1'b1;

      unique case (state_ff)
         bstk_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               data_in  = req_data;
               state_in = bstk_pkg::CS_DISPATCH;
            end
         end
         bstk_pkg::CS_DISPATCH: begin
            pal_in    = 1'b0;
            status_in = bstk_pkg::ST_OK;
            unique case (op_ff)
               bstk_pkg::OP_PUSH: begin
                  if (is_full) begin
                     status_in = bstk_pkg::ST_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  state_in = bstk_pkg::CS_RESP;
               end
               bstk_pkg::OP_POP: begin
                  if (is_empty) begin
                     status_in = bstk_pkg::ST_EMPTY;
                     state_in  = bstk_pkg::CS_RESP;
                  end else begin
                     count_in = count_ff - CW'(1);
                     idx_a_in = AW'(count_ff - CW'(1));
                     state_in = bstk_pkg::CS_POP_RD;
                  end
               end
               bstk_pkg::OP_PAL: begin
                  if (count_ff < CW'(2)) begin
                     pal_in   = 1'b1;
                     state_in = bstk_pkg::CS_RESP;
                  end else begin
                     idx_a_in = '0;
                     idx_b_in = AW'(count_ff - CW'(1));
                     state_in = bstk_pkg::CS_PAL_CMP;
                  end
               end
               bstk_pkg::OP_SHOW: begin
                  if (is_empty) begin
                     status_in = bstk_pkg::ST_EMPTY;
                     state_in  = bstk_pkg::CS_RESP;
                  end else begin
                     idx_a_in = '0;
                     state_in = bstk_pkg::CS_SHOW_RD;
                  end
               end
            endcase
         end
         bstk_pkg::CS_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = bstk_pkg::CS_IDLE;
            end
         end
         bstk_pkg::CS_POP_RD: begin
            // hold the address while stalled so the read data stays put
            res_valid             = 1'b1;
            res_item.result_value = rd_data_a;
            if (res_ready) begin
               state_in = bstk_pkg::CS_IDLE;
            end
         end
         bstk_pkg::CS_PAL_CMP: begin
            if (rd_data_a != rd_data_b) begin
               pal_in   = 1'b0;
               state_in = bstk_pkg::CS_RESP;
            end else if (span <= (AW + 1)'(2)) begin
               pal_in   = 1'b1;
               state_in = bstk_pkg::CS_RESP;
            end else begin
               idx_a_in = idx_a_ff + AW'(1);
               idx_b_in = idx_b_ff - AW'(1);
            end
         end
         bstk_pkg::CS_SHOW_RD: begin
            res_valid             = 1'b1;
            res_item.result_value = rd_data_a;
            res_item.last_result  = show_last;
            if (res_ready) begin
               if (show_last) begin
                  state_in = bstk_pkg::CS_IDLE;
               end else begin
                  idx_a_in = idx_a_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = bstk_pkg::CS_IDLE;
         end
      endcase
   end

   // Reads follow the next index so the data lines up with the index register.
   assign rd_addr_a = idx_a_in;
   assign rd_addr_b = idx_b_in;
   assign wr_addr   = AW'(count_ff);
   assign wr_data   = data_ff;

endmodule

@@ hdl/bstk_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstk_checker
// Port-level checks on the result channel of the stack.
// ---------------------------------------------------------------------------
module bstk_checker #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tuser,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 31) || (rsp_tdata[37:33] <= 5'(DEPTH)))
      else $error("entry count above depth");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != bstk_pkg::ST_OK)
         |-> rsp_tlast && (rsp_tdata[32:0] == '0))
      else $error("error result is not a lone zero result");

   a_pal_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32]
         |-> rsp_tlast && (rsp_tuser[1:0] == bstk_pkg::ST_OK)
            && (rsp_tdata[31:0] == '0))
      else $error("palindrome flag on a non-check result");

endmodule

bind bounded_stack_with_palindrome_check bstk_checker #(
   .DEPTH (DEPTH)
) u_bstk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
